// File: sv/tphi_pkg.sv
// shared constants, types and index helper for the position history block
package tphi_pkg;

	localparam int DEPTH   = 256;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int SUM_W   = CNT_W + 1;
	localparam int TIME_W  = 32;
	localparam int POS_W   = 16;
	localparam int PROD_W  = POS_W + TIME_W;
	localparam int DCNT_W  = $clog2(POS_W);

	localparam logic [TIME_W-1:0] DUR_RESET = 32'd10000000;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0]       ts;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// ring slot of the entry that is age places after base
	function automatic logic [IDX_W-1:0] slot_idx(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] age);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(age);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

// File: sv/tphi_in_if.sv
// input channel: add or query request
interface tphi_in_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [31:0]        time_stamp;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;

	modport source (output valid, operation, time_stamp, pos_x, pos_y, input ready);
	modport sink (input valid, operation, time_stamp, pos_x, pos_y, output ready);
endinterface

// File: sv/tphi_out_if.sv
// output channel: query answer
interface tphi_out_if;
	logic               valid;
	logic               ready;
	logic               in_range;
	logic               is_empty;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;

	modport source (output valid, in_range, is_empty, out_x, out_y, input ready);
	modport sink (input valid, in_range, is_empty, out_x, out_y, output ready);
endinterface

// File: sv/tphi_ram.sv
// generic single write port, single read port ram with registered read
module tphi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/timestamped_position_history_interp_top.sv
// time-stamped position ring with aging and linear interpolation
//
//  port       dir   transfer moves
//  in_ch      in    operation, time_stamp, pos_x, pos_y (add or query)
//  out_ch     out   in_range, is_empty, out_x, out_y (one per query)
//  cfg_wr_*   in    history_duration, written when cfg_wr_en is high
//
// an add writes the entry, then once aging applies reads and drops the oldest entries that are
// older than time_stamp minus duration; a query on an empty ring goes straight to its answer,
// otherwise the ring is scanned one entry per cycle through the ram read port, and when it
// interpolates a 16-step shift-subtract divider works out the fraction for x and y
// reset clears count, oldest slot and handshake state and sets duration to its default; ram contents stay
// a finished answer waits in the output register while the next request is taken

module timestamped_position_history_interp_top
	import tphi_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	tphi_in_if.sink      in_ch,
	tphi_out_if.source   out_ch,
	input  logic         cfg_wr_en,
	input  logic [31:0]  cfg_wr_data
);

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b000_0000_0001,
		ST_DROP_RD  = 11'b000_0000_0010,
		ST_DROP_CMP = 11'b000_0000_0100,
		ST_Q_LAST   = 11'b000_0000_1000,
		ST_Q_CHK    = 11'b000_0001_0000,
		ST_SCAN     = 11'b000_0010_0000,
		ST_MUL      = 11'b000_0100_0000,
		ST_DINIT    = 11'b000_1000_0000,
		ST_DIV      = 11'b001_0000_0000,
		ST_FIN      = 11'b010_0000_0000,
		ST_EMIT     = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic [TIME_W-1:0] dur_q;
	logic [IDX_W-1:0]  oldest_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  age_q;
	logic [TIME_W-1:0] t_q;
	logic [TIME_W-1:0] limit_q;
	logic              drop_en_q;

	// previous and current bracketing entries
	logic [TIME_W-1:0]       tp_q;
	logic signed [POS_W-1:0] xp_q, yp_q;
	logic [TIME_W-1:0]       tc_q;
	logic signed [POS_W-1:0] xc_q, yc_q;

	// interpolation datapath
	logic [TIME_W-1:0] den_q;
	logic              neg_x_q, neg_y_q;
	logic [PROD_W-1:0] prod_x_q, prod_y_q;
	logic [TIME_W-1:0] rem_x_q, rem_y_q;
	logic [POS_W-1:0]  quo_x_q, quo_y_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic                    res_rng_q, res_emp_q;
	logic signed [POS_W-1:0] res_x_q, res_y_q;

	logic                    out_valid_q;
	logic                    out_rng_q, out_emp_q;
	logic signed [POS_W-1:0] out_x_q, out_y_q;

	logic             in_xfer;
	logic             emit;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_wdata;
	entry_t           rd;
	logic             full;

	logic [POS_W:0]    dx, dy;
	logic [POS_W-1:0]  mag_x, mag_y;
	logic [TIME_W-1:0] num;
	logic [PROD_W-1:0] dvd_x, dvd_y;
	logic [TIME_W:0]   sh_x, sh_y, tr_x, tr_y;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign full        = (count_q == CNT_W'(DEPTH));
	assign emit        = (state_q == ST_EMIT) && (!out_valid_q || out_ch.ready);

	assign ram_we          = in_xfer && (in_ch.operation == OP_ADD);
	assign ram_waddr       = full ? oldest_q : slot_idx(oldest_q, count_q);
	assign ram_wdata.ts    = in_ch.time_stamp;
	assign ram_wdata.x     = in_ch.pos_x;
	assign ram_wdata.y     = in_ch.pos_y;

	always_comb begin
		case (state_q)
			ST_Q_LAST: ram_raddr = slot_idx(oldest_q, count_q - CNT_W'(1));
			ST_Q_CHK:  ram_raddr = slot_idx(oldest_q, CNT_W'(1));
			ST_SCAN:   ram_raddr = slot_idx(oldest_q, age_q);
			default:   ram_raddr = oldest_q;
		endcase
	end

	tphi_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd)
	);

	// sign and magnitude of the position step, fraction numerator
	assign dx    = {xc_q[POS_W-1], xc_q} - {xp_q[POS_W-1], xp_q};
	assign dy    = {yc_q[POS_W-1], yc_q} - {yp_q[POS_W-1], yp_q};
	assign mag_x = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
	assign mag_y = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
	assign num   = t_q - tp_q;

	// rounding: add half the divisor before dividing
	assign dvd_x = prod_x_q + PROD_W'(den_q >> 1);
	assign dvd_y = prod_y_q + PROD_W'(den_q >> 1);

	assign sh_x = {rem_x_q, quo_x_q[POS_W-1]};
	assign sh_y = {rem_y_q, quo_y_q[POS_W-1]};
	assign tr_x = sh_x - {1'b0, den_q};
	assign tr_y = sh_y - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dur_q       <= DUR_RESET;
			oldest_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				dur_q <= cfg_wr_data;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						t_q       <= in_ch.time_stamp;
						limit_q   <= in_ch.time_stamp - dur_q;
						drop_en_q <= (in_ch.time_stamp >= dur_q);
						if (in_ch.operation == OP_ADD) begin
							if (full) begin
								oldest_q <= slot_idx(oldest_q, CNT_W'(1));
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= ST_DROP_RD;
						end else if (count_q == '0) begin
							res_rng_q <= 1'b0;
							res_emp_q <= 1'b1;
							res_x_q   <= '0;
							res_y_q   <= '0;
							state_q   <= ST_EMIT;
						end else begin
							res_emp_q <= 1'b0;
							state_q   <= ST_Q_LAST;
						end
					end
				end
				ST_DROP_RD: begin
					if (drop_en_q && (count_q > CNT_W'(1))) begin
						state_q <= ST_DROP_CMP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DROP_CMP: begin
					if (rd.ts < limit_q) begin
						oldest_q <= slot_idx(oldest_q, CNT_W'(1));
						count_q  <= count_q - CNT_W'(1);
						state_q  <= ST_DROP_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_Q_LAST: begin
					// first entry arrives
					tp_q <= rd.ts;
					xp_q <= rd.x;
					yp_q <= rd.y;
					state_q <= ST_Q_CHK;
				end
				ST_Q_CHK: begin
					// last entry arrives, age one is being read
					res_rng_q <= (tp_q <= t_q) && (t_q <= rd.ts);
					age_q     <= CNT_W'(2);
					if ((t_q < tp_q) || (count_q == CNT_W'(1))) begin
						res_x_q <= xp_q;
						res_y_q <= yp_q;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd.ts >= t_q) begin
						if (rd.ts <= tp_q) begin
							res_x_q <= rd.x;
							res_y_q <= rd.y;
							state_q <= ST_EMIT;
						end else if (t_q <= tp_q) begin
							res_x_q <= xp_q;
							res_y_q <= yp_q;
							state_q <= ST_EMIT;
						end else begin
							tc_q    <= rd.ts;
							xc_q    <= rd.x;
							yc_q    <= rd.y;
							state_q <= ST_MUL;
						end
					end else begin
						tp_q <= rd.ts;
						xp_q <= rd.x;
						yp_q <= rd.y;
						if (age_q < count_q) begin
							age_q <= age_q + CNT_W'(1);
						end else begin
							// reached the newest entry, still older than the query time
							res_x_q <= rd.x;
							res_y_q <= rd.y;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_MUL: begin
					prod_x_q <= PROD_W'(mag_x) * PROD_W'(num);
					prod_y_q <= PROD_W'(mag_y) * PROD_W'(num);
					neg_x_q  <= dx[POS_W];
					neg_y_q  <= dy[POS_W];
					den_q    <= tc_q - tp_q;
					state_q  <= ST_DINIT;
				end
				ST_DINIT: begin
					// quotient fits in POS_W bits, so the upper part is already below den
					rem_x_q <= dvd_x[PROD_W-1:POS_W];
					rem_y_q <= dvd_y[PROD_W-1:POS_W];
					quo_x_q <= dvd_x[POS_W-1:0];
					quo_y_q <= dvd_y[POS_W-1:0];
					dcnt_q  <= DCNT_W'(POS_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!tr_x[TIME_W]) begin
						rem_x_q <= tr_x[TIME_W-1:0];
						quo_x_q <= {quo_x_q[POS_W-2:0], 1'b1};
					end else begin
						rem_x_q <= sh_x[TIME_W-1:0];
						quo_x_q <= {quo_x_q[POS_W-2:0], 1'b0};
					end
					if (!tr_y[TIME_W]) begin
						rem_y_q <= tr_y[TIME_W-1:0];
						quo_y_q <= {quo_y_q[POS_W-2:0], 1'b1};
					end else begin
						rem_y_q <= sh_y[TIME_W-1:0];
						quo_y_q <= {quo_y_q[POS_W-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q - DCNT_W'(1);
					if (dcnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					res_x_q <= neg_x_q ? (xp_q - quo_x_q) : (xp_q + quo_x_q);
					res_y_q <= neg_y_q ? (yp_q - quo_y_q) : (yp_q + quo_y_q);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						out_rng_q   <= res_rng_q;
						out_emp_q   <= res_emp_q;
						out_x_q     <= res_x_q;
						out_y_q     <= res_y_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.in_range = out_rng_q;
	assign out_ch.is_empty = out_emp_q;
	assign out_ch.out_x    = out_x_q;
	assign out_ch.out_y    = out_y_q;

endmodule
